[sv/vgrt_pkg.sv]
// ----------------------------------------------------------------------------
// vgrt_pkg: shared definitions for the voxel grid ray traversal unit
// Widths, result codes and the command/status records between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package vgrt_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int BUDGET_BITS = 16;

  localparam int ORIGIN_BITS = 32;
  localparam int HEAD_BITS   = 16;
  localparam int OUT_BITS    = 16;
  localparam int INC_BITS    = 32;
  localparam int SIDE_BITS   = 40;
  // The dividend is 2^(14+FRAC_BITS), which needs 15+FRAC_BITS bits.
  localparam int QUOT_BITS   = 15 + FRAC_BITS;
  localparam int TMAG_BITS   = FRAC_BITS + 1;
  localparam int CNT_BITS    = $clog2(QUOT_BITS);

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  localparam logic [1:0] RES_LOOKUP    = 2'd0;
  localparam logic [1:0] RES_HIT       = 2'd1;
  localparam logic [1:0] RES_EXHAUSTED = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       div_last;
    logic [1:0] axis;
    logic       mul;
    logic       advance;
    logic       emit;
    logic [1:0] emit_kind;
  } vgrt_cmd_t;

  typedef struct packed {
    logic budget_zero;
  } vgrt_status_t;

endpackage

[sv/vgrt_datapath.sv]
// ----------------------------------------------------------------------------
// vgrt_datapath: ray state, shared reciprocal divider and stepping logic
// Holds the per-axis traversal state, a one-bit-per-cycle restoring divider,
// the side distance multipliers and the output register.
// ----------------------------------------------------------------------------
module vgrt_datapath (
  input  logic                                      clk,
  input  vgrt_pkg::vgrt_cmd_t                       cmd,
  output vgrt_pkg::vgrt_status_t                    status,
  input  logic signed [vgrt_pkg::ORIGIN_BITS-1:0]   origin_x,
  input  logic signed [vgrt_pkg::ORIGIN_BITS-1:0]   origin_y,
  input  logic signed [vgrt_pkg::ORIGIN_BITS-1:0]   origin_z,
  input  logic signed [vgrt_pkg::HEAD_BITS-1:0]     heading_x,
  input  logic signed [vgrt_pkg::HEAD_BITS-1:0]     heading_y,
  input  logic signed [vgrt_pkg::HEAD_BITS-1:0]     heading_z,
  input  logic [15:0]                               step_budget,
  output logic [1:0]                                result_kind,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]      voxel_x,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]      voxel_y,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]      voxel_z,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]      previous_x,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]      previous_y,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]      previous_z,
  output logic [vgrt_pkg::OUT_BITS-1:0]             steps_left
);
  import vgrt_pkg::*;

  localparam logic signed [SIDE_BITS:0] SIDE_MAX = {2'b00, {(SIDE_BITS-1){1'b1}}};

  logic [COORD_BITS-1:0]       pos [3];
  logic [COORD_BITS-1:0]       prior [3];
  logic signed [SIDE_BITS-1:0] side [3];
  logic [INC_BITS-1:0]         inc [3];
  logic                        neg [3];
  logic [TMAG_BITS-1:0]        tmag [3];
  logic                        tneg [3];
  logic [HEAD_BITS-1:0]        hmag [3];
  logic [BUDGET_BITS-1:0]      budget;
  logic [HEAD_BITS-1:0]        rem;
  logic [QUOT_BITS-1:0]        dvd;
  logic [QUOT_BITS-1:0]        quo;

  logic signed [ORIGIN_BITS-1:0] org [3];
  logic signed [HEAD_BITS-1:0]   head [3];
  logic [COORD_BITS-1:0]         cell_ld [3];
  logic [TMAG_BITS-1:0]          tmag_ld [3];
  logic                          tneg_ld [3];
  logic [HEAD_BITS-1:0]          hmag_ld [3];
  logic signed [SIDE_BITS-1:0]   side_mul [3];

  // Start set-up: split each origin into voxel index and fraction.
  always_comb begin
    org  = '{origin_x, origin_y, origin_z};
    head = '{heading_x, heading_y, heading_z};
    for (int a = 0; a < 3; a++) begin
      logic [ORIGIN_BITS:0]           mag;
      logic [ORIGIN_BITS-FRAC_BITS:0] ip;
      logic [FRAC_BITS-1:0]           fmag;
      logic                           oneg;
      logic                           hneg;
      oneg = org[a][ORIGIN_BITS-1];
      hneg = head[a][HEAD_BITS-1];
      mag  = oneg ? (ORIGIN_BITS+1)'(-{org[a][ORIGIN_BITS-1], org[a]})
                  : {1'b0, org[a]};
      ip   = mag[ORIGIN_BITS:FRAC_BITS];
      fmag = mag[FRAC_BITS-1:0];
      cell_ld[a] = oneg ? COORD_BITS'(-ip) : COORD_BITS'(ip);
      hmag_ld[a] = hneg ? HEAD_BITS'(-head[a]) : HEAD_BITS'(head[a]);
      if (hneg) begin
        tmag_ld[a] = {1'b0, fmag};
      end else if (oneg) begin
        tmag_ld[a] = (TMAG_BITS'(1) << FRAC_BITS) + TMAG_BITS'(fmag);
      end else begin
        tmag_ld[a] = (TMAG_BITS'(1) << FRAC_BITS) - TMAG_BITS'(fmag);
      end
      tneg_ld[a] = hneg & oneg;
    end
  end

  // Restoring divider step for 2^(14+FRAC_BITS) / |heading|.
  logic [HEAD_BITS:0]   rem_sh;
  logic                 rem_ge;
  logic [HEAD_BITS:0]   rem_sub;
  logic [QUOT_BITS-1:0] quo_next;
  logic [63:0]          quo_ext;
  logic [INC_BITS-1:0]  inc_val;

  always_comb begin
    rem_sh   = {rem, dvd[QUOT_BITS-1]};
    rem_ge   = rem_sh >= {1'b0, hmag[cmd.axis]};
    rem_sub  = rem_sh - {1'b0, hmag[cmd.axis]};
    quo_next = {quo[QUOT_BITS-2:0], rem_ge};
    quo_ext  = 64'(quo_next);
    if (hmag[cmd.axis] == '0) begin
      inc_val = '1;
    end else if (quo_ext > 64'({INC_BITS{1'b1}})) begin
      inc_val = '1;
    end else begin
      inc_val = INC_BITS'(quo_ext);
    end
  end

  // Side distance set-up: |inc * t| >> FRAC_BITS with the sign of t.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [INC_BITS+TMAG_BITS-1:0] prod;
      logic [SIDE_BITS-1:0]          pmag;
      prod = inc[a] * tmag[a];
      pmag = SIDE_BITS'(prod >> FRAC_BITS);
      side_mul[a] = tneg[a] ? -$signed(pmag) : $signed(pmag);
    end
  end

  // Step selection: x only if strictly least, else y if below z, else z.
  logic [1:0]            sel;
  logic signed [SIDE_BITS:0] side_sum;
  logic signed [SIDE_BITS-1:0] side_adv;
  logic [COORD_BITS-1:0] cell_adv [3];

  always_comb begin
    if (side[0] < side[1] && side[0] < side[2]) begin
      sel = AXIS_X;
    end else if (side[1] < side[2]) begin
      sel = AXIS_Y;
    end else begin
      sel = AXIS_Z;
    end
    side_sum = $signed({side[sel][SIDE_BITS-1], side[sel]})
             + $signed({1'b0, (SIDE_BITS)'(inc[sel])});
    side_adv = (side_sum > SIDE_MAX) ? SIDE_MAX[SIDE_BITS-1:0] : side_sum[SIDE_BITS-1:0];
    for (int a = 0; a < 3; a++) begin
      if (2'(a) == sel) begin
        cell_adv[a] = neg[a] ? pos[a] - 1'b1 : pos[a] + 1'b1;
      end else begin
        cell_adv[a] = pos[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) begin
        pos[a]   <= cell_ld[a];
        prior[a] <= cell_ld[a];
        neg[a]   <= head[a][HEAD_BITS-1];
        hmag[a]  <= hmag_ld[a];
        tmag[a]  <= tmag_ld[a];
        tneg[a]  <= tneg_ld[a];
      end
      budget <= BUDGET_BITS'(step_budget);
    end
    if (cmd.div_last) begin
      inc[cmd.axis] <= inc_val;
    end
    // Initialisation for the next axis takes precedence over the last step.
    if (cmd.div_init) begin
      rem <= '0;
      dvd <= QUOT_BITS'(1) << (QUOT_BITS-1);
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_sub[HEAD_BITS-1:0] : rem_sh[HEAD_BITS-1:0];
      dvd <= dvd << 1;
      quo <= quo_next;
    end
    if (cmd.mul) begin
      for (int a = 0; a < 3; a++) begin
        side[a] <= side_mul[a];
      end
    end
    if (cmd.advance) begin
      for (int a = 0; a < 3; a++) begin
        prior[a] <= pos[a];
        pos[a]   <= cell_adv[a];
      end
      side[sel] <= side_adv;
      budget    <= budget - 1'b1;
    end
    if (cmd.emit) begin
      result_kind <= cmd.emit_kind;
      if (cmd.advance) begin
        voxel_x    <= OUT_BITS'(cell_adv[0]);
        voxel_y    <= OUT_BITS'(cell_adv[1]);
        voxel_z    <= OUT_BITS'(cell_adv[2]);
        previous_x <= OUT_BITS'(pos[0]);
        previous_y <= OUT_BITS'(pos[1]);
        previous_z <= OUT_BITS'(pos[2]);
        steps_left <= OUT_BITS'(budget - 1'b1);
      end else begin
        voxel_x    <= OUT_BITS'(pos[0]);
        voxel_y    <= OUT_BITS'(pos[1]);
        voxel_z    <= OUT_BITS'(pos[2]);
        previous_x <= OUT_BITS'(prior[0]);
        previous_y <= OUT_BITS'(prior[1]);
        previous_z <= OUT_BITS'(prior[2]);
        steps_left <= (cmd.emit_kind == RES_HIT) ? OUT_BITS'(budget) : '0;
      end
    end
  end

  assign status.budget_zero = (budget == '0);

endmodule

[sv/vgrt_ctrl.sv]
// ----------------------------------------------------------------------------
// vgrt_ctrl: sequencing state machine for the ray traversal unit
// Runs the reciprocal divider over the three axes, launches the ray and
// steps it on answers until a hit or spent budget; owns the out_valid flag.
// ----------------------------------------------------------------------------
module vgrt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic                   solid,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vgrt_pkg::vgrt_cmd_t    cmd,
  input  vgrt_pkg::vgrt_status_t status
);
  import vgrt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIVIDE   = 3'd1;
  localparam logic [2:0] S_MULTIPLY = 3'd2;
  localparam logic [2:0] S_LAUNCH   = 3'd3;
  localparam logic [2:0] S_ANSWER   = 3'd4;

  logic [2:0]          state, state_next;
  logic [1:0]          axis, axis_next;
  logic [CNT_BITS-1:0] bit_cnt, bit_cnt_next;
  logic                ray_active, ray_active_next;
  logic                hit_pending;
  logic                out_free;
  logic                in_take;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    state_next      = state;
    axis_next       = axis;
    bit_cnt_next    = bit_cnt;
    ray_active_next = ray_active;
    cmd             = '0;
    cmd.axis        = axis;
    unique case (state)
      S_IDLE: begin
        if (in_take && kind == KIND_START) begin
          cmd.load     = 1'b1;
          cmd.div_init = 1'b1;
          axis_next    = AXIS_X;
          bit_cnt_next = '0;
          state_next   = S_DIVIDE;
        end else if (in_take && ray_active) begin
          state_next = S_ANSWER;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (bit_cnt == CNT_BITS'(QUOT_BITS-1)) begin
          cmd.div_last = 1'b1;
          cmd.div_init = 1'b1;
          bit_cnt_next = '0;
          if (axis == AXIS_Z) begin
            state_next = S_MULTIPLY;
          end else begin
            axis_next = axis + 1'b1;
          end
        end else begin
          bit_cnt_next = bit_cnt + 1'b1;
        end
      end
      S_MULTIPLY: begin
        cmd.mul    = 1'b1;
        state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          if (status.budget_zero) begin
            cmd.emit_kind   = RES_EXHAUSTED;
            ray_active_next = 1'b0;
          end else begin
            cmd.emit_kind   = RES_LOOKUP;
            cmd.advance     = 1'b1;
            ray_active_next = 1'b1;
          end
        end
      end
      S_ANSWER: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          if (hit_pending) begin
            cmd.emit_kind   = RES_HIT;
            ray_active_next = 1'b0;
          end else if (status.budget_zero) begin
            cmd.emit_kind   = RES_EXHAUSTED;
            ray_active_next = 1'b0;
          end else begin
            cmd.emit_kind = RES_LOOKUP;
            cmd.advance   = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      axis       <= AXIS_X;
      bit_cnt    <= '0;
      ray_active <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      axis       <= axis_next;
      bit_cnt    <= bit_cnt_next;
      ray_active <= ray_active_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hit_pending <= solid;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result written while the output register was still occupied");

  a_start_divides: assert property (@(posedge clk) disable iff (rst)
    (in_take && kind == KIND_START) |=> (state == S_DIVIDE && axis == AXIS_X))
    else $error("ray start did not enter the divide sequence");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVIDE |-> axis <= AXIS_Z)
    else $error("divider axis counter out of range");

  a_answer_active: assert property (@(posedge clk) disable iff (rst)
    state == S_ANSWER |-> ray_active)
    else $error("answer processed without an active ray");

endmodule

[sv/voxel_grid_ray_traversal_unit.sv]
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal_unit: fixed-point 3D voxel DDA ray stepper
// Sets up a ray from a Q16.16 origin and Q1.14 direction, then issues one
// voxel lookup per step and ends on a solid voxel or a spent step budget.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Carries
//   input     in_valid / in_ready    kind, origin, heading, budget, voxel answer
//   output    out_valid / out_ready  result_kind, voxel, previous, steps_left
//
// A start transaction runs the shared restoring divider (one quotient bit
// per cycle, one axis after another), then the side distance multipliers
// and then a launch step that writes its first result.
// An answer transaction is accepted, then stepped and its result written.
// Input is accepted only while the sequencer is idle; a result waiting in the
// output register holds the launch or answer step until it has been taken.
// Reset is synchronous and active high; it clears the sequencer, the ray
// active flag and the output valid, and needs no clearing pass.
module voxel_grid_ray_traversal_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    kind,
  input  logic signed [vgrt_pkg::ORIGIN_BITS-1:0] origin_x,
  input  logic signed [vgrt_pkg::ORIGIN_BITS-1:0] origin_y,
  input  logic signed [vgrt_pkg::ORIGIN_BITS-1:0] origin_z,
  input  logic signed [vgrt_pkg::HEAD_BITS-1:0]   heading_x,
  input  logic signed [vgrt_pkg::HEAD_BITS-1:0]   heading_y,
  input  logic signed [vgrt_pkg::HEAD_BITS-1:0]   heading_z,
  input  logic [15:0]                             step_budget,
  input  logic [63:0]                             voxel_color,
  input  logic [7:0]                              voxel_flags,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [1:0]                              result_kind,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]    voxel_x,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]    voxel_y,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]    voxel_z,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]    previous_x,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]    previous_y,
  output logic signed [vgrt_pkg::OUT_BITS-1:0]    previous_z,
  output logic [vgrt_pkg::OUT_BITS-1:0]           steps_left
);
  import vgrt_pkg::*;

  vgrt_cmd_t    cmd;
  vgrt_status_t status;
  logic         solid;

  // A voxel stops the ray when its colour is not the empty pattern and the
  // pass-through flag is clear.
  assign solid = (voxel_color != '1) && !voxel_flags[4];

  vgrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .solid     (solid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  vgrt_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .origin_z    (origin_z),
    .heading_x   (heading_x),
    .heading_y   (heading_y),
    .heading_z   (heading_z),
    .step_budget (step_budget),
    .result_kind (result_kind),
    .voxel_x     (voxel_x),
    .voxel_y     (voxel_y),
    .voxel_z     (voxel_z),
    .previous_x  (previous_x),
    .previous_y  (previous_y),
    .previous_z  (previous_z),
    .steps_left  (steps_left)
  );

endmodule
